// ===== hdl/tse_pkg.sv =====
// tse_pkg: types, codes and the utf-8 step function of the sni extractor
// no dependencies
package tse_pkg;

  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_HSTYPE  = 4'd1,
    PH_SKIP    = 4'd2,
    PH_SID_LEN = 4'd3,
    PH_CS_HI   = 4'd4,
    PH_CS_LO   = 4'd5,
    PH_CM_LEN  = 4'd6,
    PH_EXT_HI  = 4'd7,
    PH_EXT_LO  = 4'd8,
    PH_EXT_HDR = 4'd9,
    PH_ENT_HDR = 4'd10,
    PH_NAME    = 4'd11
  } tse_phase_e;

  typedef enum logic [3:0] {
    ST_FOUND     = 4'd0,
    ST_SHORT     = 4'd1,
    ST_SSLV2     = 4'd2,
    ST_NOT_HS    = 4'd3,
    ST_OLD       = 4'd4,
    ST_NOT_HELLO = 4'd5,
    ST_SSL3      = 4'd6,
    ST_EXT_MIS   = 4'd7,
    ST_NO_SNI    = 4'd8,
    ST_LIST_MIS  = 4'd9,
    ST_NO_HOST   = 4'd10,
    ST_TOO_LONG  = 4'd11,
    ST_BAD_UTF8  = 4'd12,
    ST_TRUNC     = 4'd13
  } tse_status_e;

  typedef enum logic [3:0] {
    U_ACC = 4'd0,
    U_BAD = 4'd1,
    U_C1  = 4'd2,
    U_C2  = 4'd3,
    U_C3  = 4'd4,
    U_E0  = 4'd5,
    U_ED  = 4'd6,
    U_F0  = 4'd7,
    U_F4  = 4'd8
  } tse_utf8_e;

  localparam logic [7:0] HS_CONTENT_TYPE = 8'h16;
  localparam logic [7:0] CLIENT_HELLO    = 8'h01;
  localparam logic [7:0] SSLV2_MINOR     = 8'h01;
  localparam logic [5:0] FIXED_SKIP      = 6'd37;
  localparam logic [2:0] ADDR_MAX_NAME   = 3'd0;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] name_byte;
    logic [3:0] status_code;
    logic [7:0] name_length;
    logic       final_item;
  } tse_res_t;

  // results caused by one request, name byte first
  typedef struct packed {
    logic     name_vld;
    tse_res_t name;
    logic     stat_vld;
    tse_res_t stat;
  } tse_push_t;

  function automatic tse_utf8_e utf8_step(tse_utf8_e s, logic [7:0] b);
    logic c;
    tse_utf8_e r;
    c = (b >= 8'h80) && (b <= 8'hBF);
    r = U_BAD;
    unique case (s)
      U_ACC: begin
        if (b < 8'h80) r = U_ACC;
        else if (b >= 8'hC2 && b <= 8'hDF) r = U_C1;
        else if (b == 8'hE0) r = U_E0;
        else if (b == 8'hED) r = U_ED;
        else if (b >= 8'hE1 && b <= 8'hEF) r = U_C2;
        else if (b == 8'hF0) r = U_F0;
        else if (b >= 8'hF1 && b <= 8'hF3) r = U_C3;
        else if (b == 8'hF4) r = U_F4;
        else r = U_BAD;
      end
      U_C1: r = c ? U_ACC : U_BAD;
      U_C2: r = c ? U_C1 : U_BAD;
      U_C3: r = c ? U_C2 : U_BAD;
      U_E0: r = (b >= 8'hA0 && b <= 8'hBF) ? U_C1 : U_BAD;
      U_ED: r = (b >= 8'h80 && b <= 8'h9F) ? U_C1 : U_BAD;
      U_F0: r = (b >= 8'h90 && b <= 8'hBF) ? U_C2 : U_BAD;
      U_F4: r = (b >= 8'h80 && b <= 8'h8F) ? U_C2 : U_BAD;
      default: r = U_BAD;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tse_if.sv =====
// tse_req_if and tse_res_if: valid/ready channels of the sni extractor
// no dependencies
interface tse_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface tse_res_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] name_byte;
  logic [3:0] status_code;
  logic [7:0] name_length;
  logic       final_item;
  modport source (output valid, item_kind, name_byte, status_code, name_length, final_item,
                  input ready);
  modport sink (input valid, item_kind, name_byte, status_code, name_length, final_item,
                output ready);
endinterface

// ===== hdl/tse_parser.sv =====
// tse_parser: per-byte client hello walk, one byte per accepted request
// depends on tse_pkg
module tse_parser #(
  parameter int LengthWidth = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic [7:0]        max_name_length_i,
  output tse_pkg::tse_push_t push_o
);
  import tse_pkg::*;

  localparam int LW = LengthWidth;

  tse_phase_e phase_q, phase_d, after_q, after_d;
  logic [2:0] pos_q, pos_d;
  logic [LW-1:0] skip_q, skip_d, ext_q, ext_d, sni_q, sni_d, acc_q, acc_d;
  logic [7:0] vmaj_q, vmaj_d, vmin_q, vmin_d, fhb_q, fhb_d;
  tse_utf8_e utf_q, utf_d;
  logic zs_q, zs_d, dec_q, dec_d, tnz_q, tnz_d;

  logic [15:0] w16;
  logic [LW-1:0] len;
  logic ent;
  tse_phase_e ent_ph;
  logic sk;
  logic [LW-1:0] sk_cnt;
  tse_phase_e sk_ph;
  logic stat_v;
  tse_status_e stat_c;
  logic [7:0] stat_len;
  logic name_v;
  logic [7:0] name_b;
  logic ext_chk, sni_chk;

  assign w16 = {acc_q[7:0], data_byte_i};
  assign len = LW'(w16);

  always_comb begin
    phase_d = phase_q; after_d = after_q; pos_d = pos_q; skip_d = skip_q;
    ext_d = ext_q; sni_d = sni_q; acc_d = acc_q; vmaj_d = vmaj_q; vmin_d = vmin_q;
    fhb_d = fhb_q; utf_d = utf_q; zs_d = zs_q; dec_d = dec_q; tnz_d = tnz_q;
    ent = 1'b0; ent_ph = PH_HDR; sk = 1'b0; sk_cnt = '0; sk_ph = PH_HDR;
    stat_v = 1'b0; stat_c = ST_FOUND; stat_len = '0; name_v = 1'b0; name_b = '0;
    ext_chk = 1'b0; sni_chk = 1'b0;
    if (fire_i && !dec_q) begin
      unique case (phase_q)
        PH_HDR: begin
          if (pos_q == 3'd0) fhb_d = data_byte_i;
          else if (pos_q == 3'd1) vmaj_d = data_byte_i;
          else if (pos_q == 3'd2) vmin_d = data_byte_i;
          if (pos_q < 3'd4) begin
            pos_d = pos_q + 3'd1;
          end else if (fhb_q[7] && vmin_q == SSLV2_MINOR) begin
            stat_v = 1'b1; stat_c = ST_SSLV2;
          end else if (fhb_q != HS_CONTENT_TYPE) begin
            stat_v = 1'b1; stat_c = ST_NOT_HS;
          end else if (vmaj_q < 8'd3) begin
            stat_v = 1'b1; stat_c = ST_OLD;
          end else begin
            ent = 1'b1; ent_ph = PH_HSTYPE;
          end
        end
        PH_HSTYPE: begin
          if (data_byte_i != CLIENT_HELLO) begin
            stat_v = 1'b1; stat_c = ST_NOT_HELLO;
          end else begin
            sk = 1'b1; sk_cnt = LW'(FIXED_SKIP); sk_ph = PH_SID_LEN;
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - 1'b1;
          if (skip_d == '0) begin
            ent = 1'b1; ent_ph = after_q;
          end
        end
        PH_SID_LEN: begin
          sk = 1'b1; sk_cnt = LW'(data_byte_i); sk_ph = PH_CS_HI;
        end
        PH_CS_HI: begin
          acc_d = LW'(data_byte_i); phase_d = PH_CS_LO;
        end
        PH_CS_LO: begin
          sk = 1'b1; sk_cnt = len; sk_ph = PH_CM_LEN;
        end
        PH_CM_LEN: begin
          sk = 1'b1; sk_cnt = LW'(data_byte_i); sk_ph = PH_EXT_HI;
        end
        PH_EXT_HI: begin
          acc_d = LW'(data_byte_i); phase_d = PH_EXT_LO;
        end
        PH_EXT_LO: begin
          ext_d = len; ext_chk = 1'b1; sk_cnt = '0;
        end
        PH_EXT_HDR: begin
          if (pos_q < 3'd2) begin
            if (data_byte_i != 8'h00) tnz_d = 1'b1;
            pos_d = pos_q + 3'd1;
          end else if (pos_q == 3'd2) begin
            acc_d = LW'(data_byte_i); pos_d = pos_q + 3'd1;
          end else begin
            ext_d = ext_q - LW'(4);
            if (!tnz_q) begin
              if (len < LW'(2)) begin
                stat_v = 1'b1; stat_c = ST_LIST_MIS;
              end else begin
                sni_d = len - LW'(2); sni_chk = 1'b1; sk_cnt = LW'(2);
              end
            end else if (len > ext_d) begin
              stat_v = 1'b1; stat_c = ST_EXT_MIS;
            end else begin
              ext_d = ext_d - len; ext_chk = 1'b1; sk_cnt = len;
            end
          end
        end
        PH_ENT_HDR: begin
          if (pos_q == 3'd0) begin
            tnz_d = (data_byte_i != 8'h00); pos_d = pos_q + 3'd1;
          end else if (pos_q == 3'd1) begin
            acc_d = LW'(data_byte_i); pos_d = pos_q + 3'd1;
          end else begin
            sni_d = sni_q - LW'(3);
            if (!tnz_q) begin
              acc_d = len;
              if (len > LW'(max_name_length_i)) begin
                stat_v = 1'b1; stat_c = ST_TOO_LONG;
              end else if (len == '0) begin
                stat_v = 1'b1; stat_c = ST_FOUND;
              end else begin
                phase_d = PH_NAME; skip_d = len; zs_d = 1'b0; utf_d = U_ACC;
              end
            end else if (len > sni_d) begin
              stat_v = 1'b1; stat_c = ST_LIST_MIS;
            end else begin
              sni_d = sni_d - len; sni_chk = 1'b1; sk_cnt = len;
            end
          end
        end
        PH_NAME: begin
          name_v = 1'b1;
          name_b = zs_q ? 8'h00 : data_byte_i;
          if (!zs_q) begin
            if (data_byte_i == 8'h00) zs_d = 1'b1;
            else utf_d = utf8_step(utf_q, data_byte_i);
          end
          skip_d = skip_q - 1'b1;
          if (skip_d == '0) begin
            stat_v = 1'b1;
            stat_c = (utf_d == U_ACC) ? ST_FOUND : ST_BAD_UTF8;
            stat_len = (utf_d == U_ACC) ? acc_q[7:0] : 8'h00;
          end
        end
        default: begin
          stat_v = 1'b1; stat_c = ST_TRUNC;
        end
      endcase

      // list walks: a header needs four more bytes
      if (ext_chk) begin
        if (ext_d < LW'(4)) begin
          stat_v = 1'b1; stat_c = (ext_d != '0) ? ST_EXT_MIS : ST_NO_SNI;
        end else begin
          sk = 1'b1; sk_ph = PH_EXT_HDR;
        end
      end
      if (sni_chk) begin
        if (sni_d < LW'(4)) begin
          stat_v = 1'b1; stat_c = (sni_d != '0) ? ST_LIST_MIS : ST_NO_HOST;
        end else begin
          sk = 1'b1; sk_ph = PH_ENT_HDR;
        end
      end
      if (sk) begin
        if (sk_cnt == '0) begin
          ent = 1'b1; ent_ph = sk_ph;
        end else begin
          phase_d = PH_SKIP; skip_d = sk_cnt; after_d = sk_ph;
        end
      end
      if (ent) begin
        phase_d = ent_ph; pos_d = '0; tnz_d = 1'b0;
        if (ent_ph == PH_EXT_HI && last_byte_i && vmaj_d == 8'd3 && vmin_d == 8'd0) begin
          stat_v = 1'b1; stat_c = ST_SSL3;
        end
      end
      if (stat_v) dec_d = 1'b1;
    end

    // end of packet while still undecided
    if (fire_i && !dec_d && last_byte_i) begin
      stat_v = 1'b1;
      if (phase_d == PH_HDR) begin
        stat_c = ST_SHORT;
      end else if (phase_d == PH_NAME && zs_d) begin
        stat_c = (utf_d == U_ACC) ? ST_FOUND : ST_BAD_UTF8;
        stat_len = (utf_d == U_ACC) ? acc_d[7:0] : 8'h00;
      end else begin
        stat_c = ST_TRUNC;
      end
    end
    if (stat_v && stat_c != ST_FOUND) stat_len = 8'h00;
    if (stat_v && stat_c == ST_FOUND && !name_v && !(phase_d == PH_NAME)) stat_len = 8'h00;

    if (fire_i && last_byte_i) begin
      phase_d = PH_HDR; after_d = PH_HDR; pos_d = '0; skip_d = '0; ext_d = '0;
      sni_d = '0; acc_d = '0; vmaj_d = '0; vmin_d = '0; fhb_d = '0; utf_d = U_ACC;
      zs_d = 1'b0; dec_d = 1'b0; tnz_d = 1'b0;
    end
  end

  always_comb begin
    push_o.name_vld = name_v;
    push_o.name.item_kind = 1'b0;
    push_o.name.name_byte = name_b;
    push_o.name.status_code = '0;
    push_o.name.name_length = '0;
    push_o.name.final_item = 1'b0;
    push_o.stat_vld = stat_v;
    push_o.stat.item_kind = 1'b1;
    push_o.stat.name_byte = '0;
    push_o.stat.status_code = stat_c;
    push_o.stat.name_length = stat_len;
    push_o.stat.final_item = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR; after_q <= PH_HDR; pos_q <= '0; skip_q <= '0; ext_q <= '0;
      sni_q <= '0; acc_q <= '0; vmaj_q <= '0; vmin_q <= '0; fhb_q <= '0;
      utf_q <= U_ACC; zs_q <= 1'b0; dec_q <= 1'b0; tnz_q <= 1'b0;
    end else begin
      phase_q <= phase_d; after_q <= after_d; pos_q <= pos_d; skip_q <= skip_d;
      ext_q <= ext_d; sni_q <= sni_d; acc_q <= acc_d; vmaj_q <= vmaj_d;
      vmin_q <= vmin_d; fhb_q <= fhb_d; utf_q <= utf_d; zs_q <= zs_d;
      dec_q <= dec_d; tnz_q <= tnz_d;
    end
  end

`ifndef SYNTH
  a_two_only_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.name_vld && push_o.stat_vld) |-> (phase_q == PH_NAME))
    else $error("name byte and status together outside name phase");
  a_name_only_undecided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.name_vld |-> (fire_i && !dec_q))
    else $error("name byte after decision");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_byte_i) |=> (phase_q == PH_HDR && !dec_q))
    else $error("parser not cleared after last byte");
`endif

endmodule

// ===== hdl/tse_out_fifo.sv =====
// tse_out_fifo: four-entry result queue taking up to two items per cycle
// depends on tse_pkg
module tse_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tse_pkg::tse_push_t push_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               ready_i,
  output tse_pkg::tse_res_t  data_o
);
  import tse_pkg::*;

  tse_res_t mem_q [4];
  logic [1:0] wp_q, wp_d, rp_q, rp_d;
  logic [2:0] cnt_q, cnt_d;
  logic pop;
  logic [1:0] npush;

  assign pop = valid_o && ready_i;
  assign npush = {1'b0, push_i.name_vld} + {1'b0, push_i.stat_vld};
  assign valid_o = (cnt_q != 3'd0);
  assign space_o = (cnt_q <= 3'd2);
  assign data_o = mem_q[rp_q];
  assign wp_d = wp_q + npush;
  assign rp_d = rp_q + {1'b0, pop};
  assign cnt_d = cnt_q + {1'b0, npush} - {2'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.name_vld) begin
      mem_q[wp_q] <= push_i.name;
      if (push_i.stat_vld) mem_q[wp_q + 2'd1] <= push_i.stat;
    end else if (push_i.stat_vld) begin
      mem_q[wp_q] <= push_i.stat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.name_vld || push_i.stat_vld) |-> (cnt_q <= 3'd2))
    else $error("push without room");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[1:0] == 2'(wp_q - rp_q))
    else $error("queue pointers and count disagree");
`endif

endmodule

// ===== hdl/tls_sni_extractor.sv =====
// tls_sni_extractor: top level, apb register, parser and result queue
// depends on tse_pkg, tse_if, tse_parser, tse_out_fifo
// a result is written into the result queue on the clock edge that accepts its request
// throughput: one request byte per cycle while the queue has room; at most two results per byte
// the four-entry result queue holds off requests while fewer than two slots are free
// reset: asynchronous active low, parser to header phase, max_name_length to 255
module tls_sni_extractor #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tse_req_if.sink     req_i,
  tse_res_if.source   res_o
);
  import tse_pkg::*;

  logic [7:0] max_len_q;
  logic       fire;
  tse_push_t  push;
  tse_res_t   head;
  logic       space;

  // config register, single location at word zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_MAX_NAME[2]) ? {24'h0, max_len_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= 8'd255;
    end else if (psel && penable && pwrite && paddr[2] == ADDR_MAX_NAME[2]) begin
      max_len_q <= pwdata[7:0];
    end
  end

  // a request is taken whenever the queue can absorb its worst case
  assign req_i.ready = space;
  assign fire = req_i.valid && space;

  tse_parser #(.LengthWidth(LENGTH_WIDTH)) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .fire_i           (fire),
    .data_byte_i      (req_i.data_byte),
    .last_byte_i      (req_i.last_byte),
    .max_name_length_i(max_len_q),
    .push_o           (push)
  );

  tse_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .space_o(space),
    .valid_o(res_o.valid),
    .ready_i(res_o.ready),
    .data_o (head)
  );

  assign res_o.item_kind   = head.item_kind;
  assign res_o.name_byte   = head.name_byte;
  assign res_o.status_code = head.status_code;
  assign res_o.name_length = head.name_length;
  assign res_o.final_item  = head.final_item;

endmodule
